// File: hdl/hcbd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package hcbd_pkg;

    // Width of the chunk size value and of the data byte counter
    localparam int SIZE_BITS = 32;

    localparam logic [7:0] CH_CR   = 8'h0D;
    localparam logic [7:0] CH_LF   = 8'h0A;
    localparam logic [7:0] CH_SP   = 8'h20;
    localparam logic [7:0] CH_TAB  = 8'h09;
    localparam logic [7:0] CH_SEMI = 8'h3B;

    typedef enum logic [1:0] {
        ST_BUSY  = 2'd0,
        ST_DONE  = 2'd1,
        ST_ERROR = 2'd2
    } status_t;

    // {is_hex, value[3:0]}
    function automatic logic [4:0] hex_decode(input logic [7:0] b);
        logic [4:0] r;
        r = 5'd0;
        if (b >= 8'h30 && b <= 8'h39) begin
            r = {1'b1, b[3:0]};
        end
        else if ((b >= 8'h61 && b <= 8'h66) || (b >= 8'h41 && b <= 8'h46)) begin
            r = {1'b1, b[3:0] + 4'd9};
        end
        return r;
    endfunction

    function automatic logic is_blank(input logic [7:0] b);
        return (b == CH_SP) || (b == CH_TAB);
    endfunction

endpackage

`default_nettype wire

// File: hdl/http_chunked_body_decoder.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel  | Dir | tdata              | tuser
// ---------+-----+--------------------+------------------------------------
// s_*      | in  | [7:0] data_byte    | [0] restart
// m_*      | out | [7:0] body_byte    | [0] body_valid, [2:1] status
//
// One input beat gives exactly one output beat. A beat is held in an input
// register; the parser state and result register load from it once the result
// register is free, so a new beat is taken every cycle unless m_tready stalls.
// The critical path is the chunk byte counter decrement and zero test.
// rst_n clears the parser to the start of a size line; restart does the same.
// A stall on m_tready holds the result; one more beat fills the input register.

module http_chunked_body_decoder
    import hcbd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] data_byte
    input  logic       s_tuser,   // [0] restart
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] body_byte
    output logic [2:0] m_tuser    // [0] body_valid, [2:1] status
);

    typedef enum logic [3:0] {
        PH_LEAD   = 4'd0,   // leading blanks of a size line
        PH_DIGITS = 4'd1,   // inside the hex digits
        PH_TRAIL  = 4'd2,   // blanks after the digits
        PH_EXT    = 4'd3,   // chunk extension, skipped
        PH_EXTCR  = 4'd4,   // CR seen inside the extension
        PH_SZCR   = 4'd5,   // CR after the size, LF must follow
        PH_DATA   = 4'd6,   // chunk payload
        PH_DCR    = 4'd7,   // CR after payload expected
        PH_DLF    = 4'd8,   // LF after payload expected
        PH_TRLR   = 4'd9,   // trailer section
        PH_DONE   = 4'd10,
        PH_ERR    = 4'd11
    } phase_t;

    // input stage
    logic                 in_valid_reg;
    logic [7:0]           in_byte_reg;
    logic                 in_restart_reg;

    // parser state
    phase_t               phase_reg, phase_next;
    logic [SIZE_BITS-1:0] bytes_left_reg, bytes_left_next;
    logic [SIZE_BITS-1:0] size_accum_reg, size_accum_next;
    logic [1:0]           trailer_match_reg, trailer_match_next;
    logic                 trailer_first_reg, trailer_first_next;

    // result stage
    logic                 out_valid_reg;
    logic [7:0]           out_byte_reg, out_byte_next;
    logic                 out_body_valid_reg, out_body_valid_next;
    status_t              out_status_reg, out_status_next;

    logic                 out_load;

    assign out_load = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || out_load;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_byte_reg;
    assign m_tuser  = {out_status_reg, out_body_valid_reg};

    // parser step on the registered byte
    always_comb
    begin
        logic [7:0]           b;
        logic [4:0]           hx;
        logic [2:0]           m;
        logic [SIZE_BITS-1:0] left_dec;

        b        = in_byte_reg;
        hx       = hex_decode(b);
        m        = {1'b0, trailer_match_reg};
        left_dec = bytes_left_reg - {{(SIZE_BITS-1){1'b0}}, 1'b1};

        phase_next          = phase_reg;
        bytes_left_next     = bytes_left_reg;
        size_accum_next     = size_accum_reg;
        trailer_match_next  = trailer_match_reg;
        trailer_first_next  = trailer_first_reg;
        out_byte_next       = 8'd0;
        out_body_valid_next = 1'b0;

        if (in_restart_reg) begin
            phase_next         = PH_LEAD;
            bytes_left_next    = '0;
            size_accum_next    = '0;
            trailer_match_next = 2'd0;
            trailer_first_next = 1'b1;
        end
        else begin
            unique case (phase_reg)
                PH_LEAD, PH_DIGITS, PH_TRAIL:
                begin
                    if (hx[4] && phase_reg != PH_TRAIL) begin
                        // a digit that would overflow the size is an error
                        if (size_accum_reg[SIZE_BITS-1 -: 4] != 4'd0) begin
                            phase_next = PH_ERR;
                        end
                        else begin
                            size_accum_next = {size_accum_reg[SIZE_BITS-5:0], hx[3:0]};
                            phase_next      = PH_DIGITS;
                        end
                    end
                    else if (is_blank(b)) begin
                        if (phase_reg == PH_DIGITS) begin
                            phase_next = PH_TRAIL;
                        end
                    end
                    else if (phase_reg != PH_LEAD && b == CH_SEMI) begin
                        phase_next = PH_EXT;
                    end
                    else if (phase_reg != PH_LEAD && b == CH_CR) begin
                        phase_next = PH_SZCR;
                    end
                    else begin
                        phase_next = PH_ERR;
                    end
                end
                PH_EXT:
                begin
                    if (b == CH_CR) begin
                        phase_next = PH_EXTCR;
                    end
                end
                PH_EXTCR, PH_SZCR:
                begin
                    if (b == CH_LF) begin
                        // end of size line
                        if (size_accum_reg == '0) begin
                            trailer_match_next = 2'd0;
                            trailer_first_next = 1'b1;
                            phase_next         = PH_TRLR;
                        end
                        else begin
                            bytes_left_next = size_accum_reg;
                            phase_next      = PH_DATA;
                        end
                        size_accum_next = '0;
                    end
                    else if (phase_reg == PH_SZCR) begin
                        phase_next = PH_ERR;
                    end
                    else if (b != CH_CR) begin
                        phase_next = PH_EXT;
                    end
                end
                PH_DATA:
                begin
                    out_byte_next       = b;
                    out_body_valid_next = 1'b1;
                    bytes_left_next     = left_dec;
                    if (left_dec == '0) begin
                        phase_next = PH_DCR;
                    end
                end
                PH_DCR:
                begin
                    phase_next = (b == CH_CR) ? PH_DLF : PH_ERR;
                end
                PH_DLF:
                begin
                    phase_next = (b == CH_LF) ? PH_LEAD : PH_ERR;
                end
                PH_TRLR:
                begin
                    if (trailer_first_reg && m == 3'd1 && b == CH_LF) begin
                        // CRLF right after the last chunk: no trailers
                        phase_next = PH_DONE;
                    end
                    else begin
                        if (trailer_first_reg) begin
                            trailer_first_next = (m == 3'd0) && (b == CH_CR);
                        end
                        if (!m[0]) begin
                            m = (b == CH_CR) ? m + 3'd1 : 3'd0;
                        end
                        else if (b == CH_LF) begin
                            m = m + 3'd1;
                        end
                        else begin
                            m = (b == CH_CR) ? 3'd1 : 3'd0;
                        end
                        if (m[2]) begin
                            phase_next = PH_DONE;
                            m          = 3'd0;
                        end
                        trailer_match_next = m[1:0];
                    end
                end
                PH_DONE:
                begin
                end
                default:
                begin
                    phase_next = PH_ERR;
                end
            endcase
        end

        if (phase_next == PH_DONE) begin
            out_status_next = ST_DONE;
        end
        else if (phase_next == PH_ERR) begin
            out_status_next = ST_ERROR;
        end
        else begin
            out_status_next = ST_BUSY;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            in_valid_reg       <= 1'b0;
            in_byte_reg        <= 8'd0;
            in_restart_reg     <= 1'b0;
            phase_reg          <= PH_LEAD;
            bytes_left_reg     <= '0;
            size_accum_reg     <= '0;
            trailer_match_reg  <= 2'd0;
            trailer_first_reg  <= 1'b1;
            out_valid_reg      <= 1'b0;
            out_byte_reg       <= 8'd0;
            out_body_valid_reg <= 1'b0;
            out_status_reg     <= ST_BUSY;
        end
        else begin
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            if (s_tvalid && s_tready) begin
                in_byte_reg    <= s_tdata;
                in_restart_reg <= s_tuser;
            end
            if (out_load) begin
                phase_reg          <= phase_next;
                bytes_left_reg     <= bytes_left_next;
                size_accum_reg     <= size_accum_next;
                trailer_match_reg  <= trailer_match_next;
                trailer_first_reg  <= trailer_first_next;
                out_byte_reg       <= out_byte_next;
                out_body_valid_reg <= out_body_valid_next;
                out_status_reg     <= out_status_next;
                out_valid_reg      <= 1'b1;
            end
            else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

`ifndef ASSERT_OFF
    // payload beats only come out while the message is still in progress
    a_body_busy: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[0] |-> m_tuser[2:1] == ST_BUSY)
        else $error("payload beat with status not busy");

    // non-payload beats carry a zero byte
    a_body_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser[0] |-> m_tdata == 8'd0)
        else $error("nonzero body byte without body_valid");

    // in the payload phase at least one byte is still owed
    a_left_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_DATA |-> bytes_left_reg != '0)
        else $error("payload phase with zero bytes left");

    // a new size line always starts from a cleared accumulator
    a_accum_clear: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_LEAD |-> size_accum_reg == '0)
        else $error("size accumulator not clear at start of size line");

    // a result load always leaves the result register holding a valid beat
    a_load_follows: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |=> out_valid_reg)
        else $error("result register not loaded");
`endif

endmodule

`default_nettype wire

// File: tb/tb_http_chunked_body_decoder.sv
`timescale 1ns / 1ps

module tb_http_chunked_body_decoder;
    import hcbd_pkg::*;

    // Parser position, tracked by the checker's own model of the decoder
    typedef enum logic [3:0] {
        PH_LEAD,     // size line, blanks before the digits
        PH_DIGITS,   // inside the hex digits
        PH_TRAIL,    // blanks after the digits
        PH_EXT,      // chunk extension, ignored
        PH_EXTCR,    // CR seen inside an extension
        PH_SZCR,     // CR after the size, LF owed
        PH_DATA,     // payload bytes
        PH_DCR,      // CR owed after payload
        PH_DLF,      // LF owed after payload
        PH_TRLR,     // trailer section
        PH_DONE,
        PH_ERR
    } parse_phase_t;

    // One raw beat on the input side
    typedef struct packed {
        logic [7:0] data;
        logic       restart;
    } raw_beat_t;

    // One decoded beat on the output side
    typedef struct {
        logic [7:0] body;
        logic       valid;
        status_t    status;
    } decoded_t;

    localparam int IDLE_LIMIT = 2000;   // cycles with no beat on either side
    localparam int TAIL_WAIT  = 10;     // extra wait after all decoded beats are back
    localparam int HOLD_LEN   = 64;     // long receiver hold-off

    // Checker: mirrors the decoder state, keeps decoded beats still owed
    class chunk_decode_checker;
        parse_phase_t           phase;
        logic [SIZE_BITS-1:0]   remaining;
        logic [SIZE_BITS-1:0]   size_acc;
        logic [1:0]             crlf_seen;
        logic                   trl_first;
        decoded_t               decoded_q[$];
        int unsigned            errors;
        int unsigned            n_in;
        int unsigned            n_checked;
        int unsigned            n_payload;
        int unsigned            n_done;
        int unsigned            n_format_err;
        int unsigned            n_restart;

        function new();
            restart_parser();
        endfunction

        function void restart_parser();
            phase     = PH_LEAD;
            remaining = '0;
            size_acc  = '0;
            crlf_seen = 2'd0;
            trl_first = 1'b1;
        endfunction

        function int hex_digit(logic [7:0] b);
            if (b >= "0" && b <= "9") return int'(b - "0");
            if (b >= "a" && b <= "f") return int'(b - "a") + 10;
            if (b >= "A" && b <= "F") return int'(b - "A") + 10;
            return -1;
        endfunction

        function bit blank(logic [7:0] b);
            return b == CH_SP || b == CH_TAB;
        endfunction

        // A digit that would push the size past SIZE_BITS is a format error
        function void accept_digit(int d);
            if ((size_acc >> (SIZE_BITS - 4)) != 0) begin
                phase = PH_ERR;
                return;
            end
            size_acc = {size_acc[SIZE_BITS-5:0], 4'(d)};
            phase = PH_DIGITS;
        endfunction

        function void close_size_line();
            if (size_acc == 0) begin
                crlf_seen = 2'd0;
                trl_first = 1'b1;
                phase     = PH_TRLR;
            end
            else begin
                remaining = size_acc;
                phase     = PH_DATA;
            end
            size_acc = '0;
        endfunction

        // CR LF right after the zero chunk ends at once, else hunt CR LF CR LF
        function void trailer_step(logic [7:0] b);
            int unsigned m;
            m = crlf_seen;
            if (trl_first) begin
                if (m == 1 && b == CH_LF) begin
                    phase = PH_DONE;
                    return;
                end
                trl_first = (m == 0 && b == CH_CR);
            end
            if (m % 2 == 0) m = (b == CH_CR) ? m + 1 : 0;
            else if (b == CH_LF) m = m + 1;
            else m = (b == CH_CR) ? 1 : 0;
            if (m >= 4) begin
                phase = PH_DONE;
                m = 0;
            end
            crlf_seen = m[1:0];
        endfunction

        // Called on every accepted input beat
        function void take_raw_byte(logic [7:0] b, logic rs);
            decoded_t e;
            int       d;
            parse_phase_t was;
            e.body  = 8'd0;
            e.valid = 1'b0;
            was     = phase;
            n_in++;
            if (rs) begin
                restart_parser();
                n_restart++;
            end
            else begin
                d = hex_digit(b);
                case (phase)
                    PH_LEAD: begin
                        if (!blank(b)) begin
                            if (d >= 0) accept_digit(d);
                            else phase = PH_ERR;
                        end
                    end
                    PH_DIGITS: begin
                        if (d >= 0) accept_digit(d);
                        else if (blank(b)) phase = PH_TRAIL;
                        else if (b == CH_SEMI) phase = PH_EXT;
                        else if (b == CH_CR) phase = PH_SZCR;
                        else phase = PH_ERR;
                    end
                    PH_TRAIL: begin
                        if (!blank(b)) begin
                            if (b == CH_SEMI) phase = PH_EXT;
                            else if (b == CH_CR) phase = PH_SZCR;
                            else phase = PH_ERR;
                        end
                    end
                    PH_EXT: begin
                        if (b == CH_CR) phase = PH_EXTCR;
                    end
                    PH_EXTCR: begin
                        if (b == CH_LF) close_size_line();
                        else if (b != CH_CR) phase = PH_EXT;
                    end
                    PH_SZCR: begin
                        if (b == CH_LF) close_size_line();
                        else phase = PH_ERR;
                    end
                    PH_DATA: begin
                        e.body    = b;
                        e.valid   = 1'b1;
                        remaining = remaining - 1'b1;
                        if (remaining == 0) phase = PH_DCR;
                        n_payload++;
                    end
                    PH_DCR:  phase = (b == CH_CR) ? PH_DLF : PH_ERR;
                    PH_DLF:  phase = (b == CH_LF) ? PH_LEAD : PH_ERR;
                    PH_TRLR: trailer_step(b);
                    PH_DONE: begin
                    end
                    PH_ERR: begin
                    end
                    default: phase = PH_ERR;
                endcase
            end
            if (phase == PH_DONE && was != PH_DONE) n_done++;
            if (phase == PH_ERR && was != PH_ERR) n_format_err++;
            e.status = (phase == PH_DONE) ? ST_DONE :
                       (phase == PH_ERR) ? ST_ERROR : ST_BUSY;
            decoded_q.push_back(e);
        endfunction

        function int unsigned pending();
            return decoded_q.size();
        endfunction

        task report(string msg);
            errors++;
            $display("[%0t] mismatch: %s", $realtime, msg);
        endtask

        // Called on every accepted output beat
        task check_decoded(logic [7:0] data, logic [2:0] user);
            decoded_t e;
            if (decoded_q.size() == 0) begin
                report($sformatf("beat with nothing owed: tdata=%h tuser=%b", data, user));
                return;
            end
            e = decoded_q.pop_front();
            if (data !== e.body || user[0] !== e.valid || user[2:1] !== e.status)
                report($sformatf("out beat %0d: got byte=%h valid=%b status=%0d, want byte=%h valid=%b status=%0d",
                                 n_checked, data, user[0], user[2:1], e.body, e.valid, e.status));
            n_checked++;
        endtask
    endclass

    logic       clk      = 1'b0;
    logic       rst_n    = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata  = 8'd0;   // [7:0] data_byte
    logic       s_tuser  = 1'b0;   // [0] restart
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;           // [7:0] body_byte
    logic [2:0] m_tuser;           // [0] body_valid, [2:1] status

    chunk_decode_checker sb;
    raw_beat_t           stim_q[$];
    int unsigned         n_directed;
    int unsigned         idle_cycles = 0;
    string               hex_chars = "0123456789abcdefABCDEF";

    http_chunked_body_decoder dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #5 clk = ~clk;

    // ---------------------------------------------------------------
    // Stimulus builders: append raw beats to stim_q
    // ---------------------------------------------------------------
    function automatic void add_byte(logic [7:0] b);
        raw_beat_t r;
        r.data    = b;
        r.restart = 1'b0;
        stim_q.push_back(r);
    endfunction

    // restart beat: the data byte rides along and must be ignored
    function automatic void add_restart();
        raw_beat_t r;
        r.data    = 8'($urandom_range(0, 255));
        r.restart = 1'b1;
        stim_q.push_back(r);
    endfunction

    function automatic void add_crlf();
        add_byte(CH_CR);
        add_byte(CH_LF);
    endfunction

    function automatic void add_blanks();
        repeat ($urandom_range(1, 2)) add_byte($urandom_range(0, 1) ? CH_SP : CH_TAB);
    endfunction

    // hex digits of v, each letter in random case
    function automatic void add_hex(logic [31:0] v);
        string      s;
        logic [7:0] c;
        s = $sformatf("%0h", v);
        for (int i = 0; i < s.len(); i++) begin
            c = s[i];
            if (c >= "a" && c <= "f" && $urandom_range(0, 1) == 1) c = c - 8'h20;
            add_byte(c);
        end
    endfunction

    // size line with optional blanks, leading zeros and extension
    function automatic void add_size_line(logic [31:0] v);
        if ($urandom_range(0, 2) == 0) add_blanks();
        if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 2)) add_byte("0");
        add_hex(v);
        if ($urandom_range(0, 3) == 0) add_blanks();
        if ($urandom_range(0, 2) == 0) begin
            add_byte(CH_SEMI);
            repeat ($urandom_range(0, 5)) begin
                case ($urandom_range(0, 4))
                    0: begin
                        add_byte(CH_CR);      // lone CR inside the extension
                        add_byte("x");
                    end
                    1: begin
                        add_byte(CH_CR);
                        add_byte(CH_CR);
                    end
                    default: add_byte(8'($urandom_range(8'h20, 8'h7e)));
                endcase
            end
        end
        add_crlf();
    endfunction

    // full message: up to three chunks, zero chunk, optional trailers
    function automatic void add_message(bit corrupt);
        int unsigned start;
        int unsigned sz;
        start = stim_q.size();
        add_restart();
        repeat ($urandom_range(0, 3)) begin
            sz = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 48) : $urandom_range(1, 8);
            add_size_line(sz);
            repeat (sz) add_byte(8'($urandom_range(0, 255)));
            add_crlf();
        end
        add_size_line(32'd0);
        if ($urandom_range(0, 1) == 1) add_crlf();
        else begin
            repeat ($urandom_range(1, 2)) begin
                repeat ($urandom_range(1, 6)) begin
                    case ($urandom_range(0, 7))
                        0: add_byte(CH_CR);
                        1: add_byte(CH_LF);
                        default: add_byte(8'($urandom_range(8'h20, 8'h7e)));
                    endcase
                end
                add_crlf();
            end
            add_crlf();
        end
        if (corrupt)
            stim_q[start + $urandom_range(1, stim_q.size() - start - 1)].data =
                8'($urandom_range(0, 255));
    endfunction

    // malformed or cut-short messages
    function automatic void add_broken();
        int unsigned sz;
        case ($urandom_range(0, 5))
            0: add_message(1'b1);
            1: begin
                // too many significant digits for SIZE_BITS
                add_restart();
                if ($urandom_range(0, 1) == 1) add_byte("0");
                add_hex(32'h1 + $urandom_range(0, 14));
                repeat (8) add_byte(hex_chars[$urandom_range(0, 21)]);
                add_crlf();
            end
            2: begin
                // empty size
                add_restart();
                if ($urandom_range(0, 1) == 1) add_blanks();
                add_byte($urandom_range(0, 1) ? CH_SEMI : CH_CR);
                add_crlf();
            end
            3: begin
                // largest sizes that still fit, with the payload cut short
                add_restart();
                add_size_line(($urandom_range(0, 3) == 0) ? 32'hFFFF_FFFF
                                                          : ($urandom | 32'h1000_0000));
                repeat ($urandom_range(1, 6)) add_byte(8'($urandom_range(0, 255)));
            end
            4: begin
                // blank between two digits
                add_restart();
                add_hex($urandom_range(1, 15));
                add_byte($urandom_range(0, 1) ? CH_SP : CH_TAB);
                add_hex($urandom_range(1, 15));
                add_crlf();
            end
            default: begin
                // bad CR LF after data, or CR not followed by LF in the size line
                add_restart();
                sz = $urandom_range(1, 4);
                case ($urandom_range(0, 2))
                    0: begin
                        add_size_line(sz);
                        repeat (sz) add_byte(8'($urandom_range(0, 255)));
                        add_byte(CH_LF);
                    end
                    1: begin
                        add_size_line(sz);
                        repeat (sz) add_byte(8'($urandom_range(0, 255)));
                        add_byte(CH_CR);
                        add_byte("x");
                    end
                    default: begin
                        add_hex(sz);
                        add_byte(CH_CR);
                        add_byte("x");
                    end
                endcase
            end
        endcase
        repeat ($urandom_range(0, 2)) add_byte(8'($urandom_range(0, 255)));
    endfunction

    // ---------------------------------------------------------------
    // Input side: one beat, held until s_tready at a rising edge
    // ---------------------------------------------------------------
    task automatic push_beat(raw_beat_t b);
        s_tvalid <= 1'b1;
        s_tdata  <= b.data;
        s_tuser  <= b.restart;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        sb.take_raw_byte(b.data, b.restart);
    endtask

    // ---------------------------------------------------------------
    // Main sequence
    // ---------------------------------------------------------------
    initial begin : stimulus
        int unsigned burst_left;
        int unsigned pick;
        sb = new();

        // Directed: restart with all-ones data, blanks around the size,
        // extension holding a lone CR, zero payload byte, zero chunk
        // ending at once, byte after done, empty size, byte after error,
        // then a zero chunk followed by a trailer line.
        stim_q.push_back('{data: 8'hFF, restart: 1'b1});
        add_byte(CH_SP);
        add_byte("1");
        add_byte(CH_TAB);
        add_byte(CH_SEMI);
        add_byte(CH_CR);
        add_byte(".");
        add_crlf();
        add_byte(8'h00);
        add_crlf();
        add_byte("0");
        add_crlf();
        add_crlf();
        add_byte(8'hFF);
        add_restart();
        add_byte(CH_CR);
        add_byte("F");
        add_restart();
        add_byte("0");
        add_crlf();
        add_byte("X");
        add_crlf();
        add_crlf();
        n_directed = stim_q.size();

        // Random: mostly well-formed messages with random content
        while (stim_q.size() < n_directed + 450) begin
            pick = $urandom_range(0, 99);
            if (pick < 70) add_message(1'b0);
            else if (pick < 92) add_broken();
            else repeat ($urandom_range(2, 8)) begin
                if ($urandom_range(0, 7) == 0) add_restart();
                else add_byte(8'($urandom_range(0, 255)));
            end
        end

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Bursts with random gaps; after the directed part and halfway the
        // sender waits until every decoded beat is back.
        burst_left = $urandom_range(1, 40);
        for (int i = 0; i < stim_q.size(); i++) begin
            if (i == n_directed || i == stim_q.size() / 2) begin
                s_tvalid <= 1'b0;
                @(posedge clk);
                while (sb.pending() != 0) @(posedge clk);
            end
            else if (burst_left == 0) begin
                burst_left = $urandom_range(1, 40);
                if ($urandom_range(0, 2) != 0) begin
                    s_tvalid <= 1'b0;
                    repeat ($urandom_range(1, 8)) @(posedge clk);
                end
            end
            else burst_left--;
            push_beat(stim_q[i]);
        end
        s_tvalid <= 1'b0;

        while (sb.pending() != 0) @(posedge clk);
        repeat (TAIL_WAIT) @(posedge clk);
        if (sb.pending() != 0) sb.report($sformatf("%0d decoded beats never came", sb.pending()));

        $display("covered %0d input beats, %0d payload bytes, %0d restarts",
                 sb.n_in, sb.n_payload, sb.n_restart);
        $display("covered %0d completed messages and %0d format errors",
                 sb.n_done, sb.n_format_err);
        if (sb.errors == 0) begin
            $display("PASS");
        end
        else begin
            $display("FAIL");
        end
        $finish;
    end

    // ---------------------------------------------------------------
    // Output side: ready pattern switches among 100, 70 and 35 percent; two long
    // hold-offs fill the block and push back on s_tready.
    // ---------------------------------------------------------------
    initial begin : sink
        int unsigned hold_left;
        int unsigned mode_left;
        int unsigned ready_pct;
        bit          hold1_done;
        bit          hold2_done;
        hold_left  = 0;
        mode_left  = 0;
        ready_pct  = 100;
        hold1_done = 1'b0;
        hold2_done = 1'b0;
        @(posedge rst_n);
        forever begin
            @(posedge clk);
            if (m_tvalid && m_tready) sb.check_decoded(m_tdata, m_tuser);
            if (!hold1_done && sb.n_checked >= 120) begin
                hold1_done = 1'b1;
                hold_left  = HOLD_LEN;
            end
            if (!hold2_done && sb.n_checked >= 320) begin
                hold2_done = 1'b1;
                hold_left  = HOLD_LEN;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else begin
                if (mode_left == 0) begin
                    mode_left = $urandom_range(10, 60);
                    case ($urandom_range(0, 2))
                        0: ready_pct = 100;
                        1: ready_pct = 70;
                        default: ready_pct = 35;
                    endcase
                end
                mode_left--;
                m_tready <= ($urandom_range(1, 100) <= ready_pct);
            end
        end
    end

    // Watchdog: no beat on either side for too long
    always @(posedge clk) begin
        if (!rst_n) begin
            idle_cycles <= 0;
        end
        else if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end
        else if (idle_cycles >= IDLE_LIMIT) begin
            $display("timeout: no beat for %0d cycles", IDLE_LIMIT);
            $display("FAIL");
            $finish;
        end
        else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

endmodule
